### sv/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg: shared definitions for the bracket balance checker
// Holds the byte codes, verdict and kind codes, and the stack control struct.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int unsigned StackDepthDefault = 64;
  localparam int unsigned KindW             = 2;
  localparam int unsigned PosW              = 16;
  localparam int unsigned VerdictW          = 2;

  localparam logic [7:0] ByteNewline    = 8'd10;
  localparam logic [7:0] ByteRoundOpen  = 8'h28;
  localparam logic [7:0] ByteRoundClose = 8'h29;
  localparam logic [7:0] ByteSqOpen     = 8'h5B;
  localparam logic [7:0] ByteSqClose    = 8'h5D;
  localparam logic [7:0] ByteCurlyOpen  = 8'h7B;
  localparam logic [7:0] ByteCurlyClose = 8'h7D;

  localparam logic [KindW-1:0] KindRound = 2'd0;
  localparam logic [KindW-1:0] KindSq    = 2'd1;
  localparam logic [KindW-1:0] KindCurly = 2'd2;

  localparam logic [VerdictW-1:0] VerdictBalanced = 2'd0;
  localparam logic [VerdictW-1:0] VerdictCloser   = 2'd1;
  localparam logic [VerdictW-1:0] VerdictUnclosed = 2'd2;
  localparam logic [VerdictW-1:0] VerdictOverflow = 2'd3;

  localparam logic [PosW-1:0] PosMax = 16'hFFFF;

  // Control handed from the line controller to the stack chain.
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [KindW-1:0] kind;
  } stack_ctrl_t;

endpackage

### sv/bbc_cell.sv
// ----------------------------------------------------------------------------
// bbc_cell: one entry of the shifting bracket stack
// Takes its upper neighbor's kind on a push and its lower neighbor's on a pop.
// ----------------------------------------------------------------------------
module bbc_cell (
  input  logic                       clk_i,
  input  logic                       push_i,
  input  logic                       pop_i,
  input  logic [bbc_pkg::KindW-1:0]  above_i,
  input  logic [bbc_pkg::KindW-1:0]  below_i,
  output logic [bbc_pkg::KindW-1:0]  kind_o
);

  logic [bbc_pkg::KindW-1:0] kind_q, kind_d;

  always_comb begin
    kind_d = kind_q;
    if (push_i) begin
      kind_d = above_i;
    end else if (pop_i) begin
      kind_d = below_i;
    end
  end

  // Payload only: entries are meaningful once pushed.
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
  end

  assign kind_o = kind_q;

endmodule

### sv/bbc_stack.sv
// ----------------------------------------------------------------------------
// bbc_stack: row of stack cells, top of stack in cell zero
// A push shifts every entry one cell down, a pop shifts them one cell up.
// ----------------------------------------------------------------------------
module bbc_stack #(
  parameter int unsigned StackDepth = bbc_pkg::StackDepthDefault
) (
  input  logic                       clk_i,
  input  bbc_pkg::stack_ctrl_t       ctrl_i,
  output logic [bbc_pkg::KindW-1:0]  top_kind_o
);

  logic [bbc_pkg::KindW-1:0] kind_w [StackDepth];

  for (genvar i = 0; i < StackDepth; i++) begin : g_cell
    logic [bbc_pkg::KindW-1:0] above_w, below_w;

    if (i == 0) begin : g_top
      assign above_w = ctrl_i.kind;
    end else begin : g_mid
      assign above_w = kind_w[i-1];
    end

    if (i == StackDepth - 1) begin : g_bot
      assign below_w = kind_w[i];
    end else begin : g_up
      assign below_w = kind_w[i+1];
    end

    bbc_cell u_cell (
      .clk_i   (clk_i),
      .push_i  (ctrl_i.push),
      .pop_i   (ctrl_i.pop),
      .above_i (above_w),
      .below_i (below_w),
      .kind_o  (kind_w[i])
    );
  end

  assign top_kind_o = kind_w[0];

endmodule

### sv/bracket_balance_checker_unit.sv
// ----------------------------------------------------------------------------
// bracket_balance_checker_unit: per-line bracket balance checker
// Each result of an accepted byte is registered in the output register, or in the skid slot
// while the output register is held. Throughput: one byte per cycle while the skid slot is
// empty, set by the single push, pop or top compare on cell zero of the stack chain. Two
// result slots (output register and skid) keep the slave side open while a result waits.
// Reset (rst_ni low, asynchronous) empties the stack, clears the position and
// error state and drops both result slots; stack cell contents are not reset.
// ----------------------------------------------------------------------------
module bracket_balance_checker_unit #(
  parameter int unsigned StackDepth = bbc_pkg::StackDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave side: one text byte per transaction.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_byte
  // Master side: one verdict per transaction.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // [1:0] verdict, [17:2] position,
                                        // [19:18] bracket_kind, [23:20] zero
);

  localparam int unsigned SpW  = $clog2(StackDepth + 1);
  localparam int unsigned ResW = bbc_pkg::VerdictW + bbc_pkg::PosW + bbc_pkg::KindW;
  localparam logic [SpW-1:0] SpFull = SpW'(StackDepth);

  // --------------------------------------------------------------------------
  // Byte decode.
  // --------------------------------------------------------------------------
  logic                       in_accept;
  logic                       is_newline, is_open, is_close;
  logic [bbc_pkg::KindW-1:0]  byte_kind;

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    is_open   = 1'b0;
    is_close  = 1'b0;
    byte_kind = bbc_pkg::KindRound;
    case (s_axis_tdata_i)
      bbc_pkg::ByteRoundOpen:  begin is_open  = 1'b1; byte_kind = bbc_pkg::KindRound; end
      bbc_pkg::ByteRoundClose: begin is_close = 1'b1; byte_kind = bbc_pkg::KindRound; end
      bbc_pkg::ByteSqOpen:     begin is_open  = 1'b1; byte_kind = bbc_pkg::KindSq;    end
      bbc_pkg::ByteSqClose:    begin is_close = 1'b1; byte_kind = bbc_pkg::KindSq;    end
      bbc_pkg::ByteCurlyOpen:  begin is_open  = 1'b1; byte_kind = bbc_pkg::KindCurly; end
      bbc_pkg::ByteCurlyClose: begin is_close = 1'b1; byte_kind = bbc_pkg::KindCurly; end
      default: begin
        is_open  = 1'b0;
        is_close = 1'b0;
      end
    endcase
  end

  assign is_newline = (s_axis_tdata_i == bbc_pkg::ByteNewline);

  // --------------------------------------------------------------------------
  // Line state. The stack depth count lives here; the kinds live in the chain.
  // The outermost opener's kind is captured when it is pushed on an empty
  // stack, so the unclosed report never needs the bottom cell.
  // --------------------------------------------------------------------------
  logic [SpW-1:0]             sp_q, sp_d;
  logic [bbc_pkg::PosW-1:0]   pos_q, pos_d, pos_inc;
  logic [bbc_pkg::PosW-1:0]   outer_pos_q, outer_pos_d;
  logic [bbc_pkg::KindW-1:0]  outer_kind_q, outer_kind_d;
  logic                       failed_q, failed_d;
  logic [bbc_pkg::KindW-1:0]  top_kind;
  bbc_pkg::stack_ctrl_t       stack_ctrl;

  logic                       res_new;
  logic [ResW-1:0]            res_data;

  assign pos_inc = (pos_q == bbc_pkg::PosMax) ? pos_q : pos_q + 1'b1;

  always_comb begin
    sp_d            = sp_q;
    pos_d           = pos_q;
    outer_pos_d     = outer_pos_q;
    outer_kind_d    = outer_kind_q;
    failed_d        = failed_q;
    stack_ctrl.push = 1'b0;
    stack_ctrl.pop  = 1'b0;
    stack_ctrl.kind = byte_kind;
    res_new         = 1'b0;
    res_data        = '0;

    if (in_accept) begin
      if (is_newline) begin
        // End of line: report unless an error was already given, then clear.
        if (!failed_q) begin
          res_new = 1'b1;
          if (sp_q == '0) begin
            res_data = {bbc_pkg::KindRound, {bbc_pkg::PosW{1'b0}}, bbc_pkg::VerdictBalanced};
          end else begin
            res_data = {outer_kind_q, outer_pos_q, bbc_pkg::VerdictUnclosed};
          end
        end
        sp_d        = '0;
        pos_d       = '0;
        outer_pos_d = '0;
        failed_d    = 1'b0;
      end else begin
        pos_d = pos_inc;
        if (!failed_q) begin
          if (is_open) begin
            if (sp_q == SpFull) begin
              failed_d = 1'b1;
              res_new  = 1'b1;
              res_data = {byte_kind, pos_inc, bbc_pkg::VerdictOverflow};
            end else begin
              if (sp_q == '0) begin
                outer_pos_d  = pos_inc;
                outer_kind_d = byte_kind;
              end
              stack_ctrl.push = 1'b1;
              sp_d            = sp_q + 1'b1;
            end
          end else if (is_close) begin
            if ((sp_q == '0) || (top_kind != byte_kind)) begin
              failed_d = 1'b1;
              res_new  = 1'b1;
              res_data = {byte_kind, pos_inc, bbc_pkg::VerdictCloser};
            end else begin
              stack_ctrl.pop = 1'b1;
              sp_d           = sp_q - 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q         <= '0;
      pos_q        <= '0;
      outer_pos_q  <= '0;
      outer_kind_q <= bbc_pkg::KindRound;
      failed_q     <= 1'b0;
    end else begin
      sp_q         <= sp_d;
      pos_q        <= pos_d;
      outer_pos_q  <= outer_pos_d;
      outer_kind_q <= outer_kind_d;
      failed_q     <= failed_d;
    end
  end

  bbc_stack #(
    .StackDepth (StackDepth)
  ) u_stack (
    .clk_i      (clk_i),
    .ctrl_i     (stack_ctrl),
    .top_kind_o (top_kind)
  );

  // --------------------------------------------------------------------------
  // Result slots. The output register drives the master side; the skid slot
  // catches a result made while the output register is still held. The slave
  // side stalls only while the skid slot is occupied.
  // --------------------------------------------------------------------------
  logic            out_valid_q, out_valid_d;
  logic            skid_valid_q, skid_valid_d;
  logic [ResW-1:0] out_data_q, out_data_d;
  logic [ResW-1:0] skid_data_q, skid_data_d;
  logic            out_free;

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = res_new;
        out_data_d  = res_data;
      end
    end else if (res_new) begin
      skid_valid_d = 1'b1;
      skid_data_d  = res_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign s_axis_tready_o = !skid_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(24 - ResW){1'b0}}, out_data_q};

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot holds a result while the output register is empty");

  a_sp_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpFull)
    else $error("stack depth count beyond the number of cells");

  a_newline_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && is_newline) |=> (sp_q == '0) && (pos_q == '0) && !failed_q)
    else $error("line state not cleared after a newline");

  a_failed_no_stack : assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |-> !stack_ctrl.push && !stack_ctrl.pop)
    else $error("stack moved on a line that already failed");

  a_overflow_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_new && (res_data[bbc_pkg::VerdictW-1:0] == bbc_pkg::VerdictOverflow))
      |-> (sp_q == SpFull))
    else $error("overflow reported with room left on the stack");

endmodule

### bench/bracket_balance_checker_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bracket_balance_checker_unit_tb: self-checking bench for the bracket checker
// Streams text lines into the checker and predicts every line verdict. The
// lines include hand-picked cases, nesting at the stack limit, and random
// lines. Random stalls are applied on both sides, and the output is held off
// once so that the checker's input backs up.
// ----------------------------------------------------------------------------
module bracket_balance_checker_unit_tb;
  import bbc_pkg::*;

  localparam int unsigned RandomItems = 950;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 8;

  // Field layout of m_axis_tdata_o, most significant field first.
  typedef struct packed {
    logic [3:0]          pad;
    logic [KindW-1:0]    kind;
    logic [PosW-1:0]     position;
    logic [VerdictW-1:0] verdict;
  } verdict_t;

  // Tracks the bracket state of the current line and queues the verdicts
  // that the checker owes.
  class bracket_scoreboard;
    logic [KindW-1:0] open_stack[StackDepthDefault];
    int unsigned      open_count;
    logic [PosW-1:0]  line_pos;
    logic [PosW-1:0]  outer_pos;
    bit               line_failed;
    verdict_t         verdict_q[$];
    int unsigned      failures;

    function void start_line();
      open_count  = 0;
      line_pos    = '0;
      outer_pos   = '0;
      line_failed = 1'b0;
    endfunction

    function void owe(logic [VerdictW-1:0] v, logic [PosW-1:0] p, logic [KindW-1:0] k);
      verdict_t rec;
      rec.pad      = '0;
      rec.kind     = k;
      rec.position = p;
      rec.verdict  = v;
      verdict_q.push_back(rec);
    endfunction

    function void note_byte(logic [7:0] b);
      logic [KindW-1:0] k;
      bit               is_open;
      bit               is_close;
      is_open  = 1'b0;
      is_close = 1'b0;
      k        = KindRound;
      if (b == ByteNewline) begin
        // A failed line already reported; otherwise the newline gives the verdict.
        if (!line_failed) begin
          if (open_count == 0) owe(VerdictBalanced, '0, KindRound);
          else owe(VerdictUnclosed, outer_pos, open_stack[0]);
        end
        start_line();
        return;
      end
      if (line_pos != PosMax) line_pos++;
      if (line_failed) return;
      case (b)
        ByteRoundOpen:  begin is_open  = 1'b1; k = KindRound; end
        ByteSqOpen:     begin is_open  = 1'b1; k = KindSq;    end
        ByteCurlyOpen:  begin is_open  = 1'b1; k = KindCurly; end
        ByteRoundClose: begin is_close = 1'b1; k = KindRound; end
        ByteSqClose:    begin is_close = 1'b1; k = KindSq;    end
        ByteCurlyClose: begin is_close = 1'b1; k = KindCurly; end
        default: ;
      endcase
      if (is_open) begin
        if (open_count >= StackDepthDefault) begin
          line_failed = 1'b1;
          owe(VerdictOverflow, line_pos, k);
        end else begin
          if (open_count == 0) outer_pos = line_pos;
          open_stack[open_count] = k;
          open_count++;
        end
      end else if (is_close) begin
        if (open_count == 0 || open_stack[open_count - 1] != k) begin
          line_failed = 1'b1;
          owe(VerdictCloser, line_pos, k);
        end else begin
          open_count--;
        end
      end
    endfunction

    function void check_verdict(logic [23:0] data);
      verdict_t got;
      verdict_t want;
      got = verdict_t'(data);
      if (verdict_q.size() == 0) begin
        $error("unexpected verdict transaction: tdata %h", data);
        failures++;
        return;
      end
      want = verdict_q.pop_front();
      if (got.verdict !== want.verdict) begin
        $error("verdict: expected %0d, actual %0d", want.verdict, got.verdict);
        failures++;
      end
      if (got.position !== want.position) begin
        $error("position: expected %0d, actual %0d", want.position, got.position);
        failures++;
      end
      if (got.kind !== want.kind) begin
        $error("bracket_kind: expected %0d, actual %0d", want.kind, got.kind);
        failures++;
      end
      if (got.pad !== want.pad) begin
        $error("tdata pad: expected %0d, actual %0d", want.pad, got.pad);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic [7:0]  s_axis_tdata_i  = 8'h00;
  logic        m_axis_tready_i = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [23:0] m_axis_tdata_o;

  bracket_scoreboard line_checker;

  // Shared between the stimulus and the output side.
  bit          idle_en      = 1'b1;
  bit          hold_request = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;

  // Line under construction and the kinds it has left open.
  logic [7:0]       line_q[$];
  logic [KindW-1:0] open_kinds[$];

  bracket_balance_checker_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Output side: check each verdict transaction, stall at random, and honor a
  // request for one long hold-off that backs the checker up.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) line_checker.check_verdict(m_axis_tdata_o);
      if (hold_request) begin
        hold_left    = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= !(idle_en && $urandom_range(99) < 16);
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  function automatic logic [7:0] opener_of(logic [KindW-1:0] k);
    case (k)
      KindRound: return ByteRoundOpen;
      KindSq:    return ByteSqOpen;
      default:   return ByteCurlyOpen;
    endcase
  endfunction

  function automatic logic [7:0] closer_of(logic [KindW-1:0] k);
    case (k)
      KindRound: return ByteRoundClose;
      KindSq:    return ByteSqClose;
      default:   return ByteCurlyClose;
    endcase
  endfunction

  function automatic logic [KindW-1:0] random_kind();
    case ($urandom_range(2))
      0:       return KindRound;
      1:       return KindSq;
      default: return KindCurly;
    endcase
  endfunction

  // Any byte that is neither a bracket nor a newline.
  function automatic logic [7:0] filler_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b inside {ByteNewline, ByteRoundOpen, ByteRoundClose, ByteSqOpen,
                     ByteSqClose, ByteCurlyOpen, ByteCurlyClose});
    return b;
  endfunction

  function automatic void add_opener();
    logic [KindW-1:0] k;
    k = random_kind();
    open_kinds.push_back(k);
    line_q.push_back(opener_of(k));
  endfunction

  // Closes the innermost open bracket; now and then with the wrong kind.
  function automatic void add_closer(bit may_corrupt);
    logic [KindW-1:0] k;
    k = open_kinds.pop_back();
    if (may_corrupt && $urandom_range(29) == 0) k = (k == KindCurly) ? KindRound : k + 1'b1;
    line_q.push_back(closer_of(k));
  endfunction

  // Builds one random line into line_q, newline included. Most lines are
  // properly nested with random content; some are deep enough to reach the
  // stack limit, some are left open or carry a stray closer, and some are
  // plain noise.
  function automatic void build_line();
    int unsigned flavor;
    int unsigned depth_cap;
    int unsigned steps;
    line_q.delete();
    open_kinds.delete();
    flavor    = $urandom_range(99);
    depth_cap = 8;
    if (flavor < 12) begin
      steps = $urandom_range(1, 24);
      repeat (steps) begin
        if ($urandom_range(1) == 0) line_q.push_back(8'($urandom_range(255)));
        else if ($urandom_range(1) == 0) line_q.push_back(opener_of(random_kind()));
        else line_q.push_back(closer_of(random_kind()));
      end
    end else begin
      if (flavor < 17) begin
        depth_cap = StackDepthDefault + 2;
        repeat ($urandom_range(StackDepthDefault - 2, StackDepthDefault + 2)) begin
          add_opener();
          if ($urandom_range(9) == 0) line_q.push_back(filler_byte());
        end
      end
      steps = $urandom_range(2, 30);
      repeat (steps) begin
        case ($urandom_range(2))
          0: line_q.push_back(filler_byte());
          1: if (open_kinds.size() < depth_cap) add_opener();
          default: if (open_kinds.size() != 0) add_closer(1'b1);
        endcase
      end
      if ($urandom_range(4) != 0) begin
        while (open_kinds.size() != 0) add_closer(1'b1);
      end
      if ($urandom_range(19) == 0) line_q.push_back(closer_of(random_kind()));
    end
    line_q.push_back(ByteNewline);
  endfunction

  // Offers one byte and returns once the checker has taken it. The valid is
  // only dropped when an idle cycle is inserted, so back-to-back bytes keep
  // it high.
  task automatic send_byte(input logic [7:0] b);
    if (idle_en) begin
      while ($urandom_range(99) < 16) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    line_checker.note_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_built_line();
    foreach (line_q[i]) send_byte(line_q[i]);
  endtask

  initial begin
    int unsigned sent;
    int unsigned line_no;
    line_checker = new;
    line_checker.start_line();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Hand-picked lines: empty, nested, unclosed with extreme filler bytes,
    // a closer on an empty stack, and a closer of the wrong kind.
    send_text("\n");
    send_text("([{}])\n");
    send_byte(8'hFF);
    send_text("{(");
    send_byte(8'h00);
    send_text(")\n");
    send_text(")]\n");
    send_text("[}\n");
    send_text("(]\n");

    // Exactly a full stack closes cleanly; one more opener overflows.
    line_q.delete();
    open_kinds.delete();
    repeat (StackDepthDefault) add_opener();
    repeat (StackDepthDefault) add_closer(1'b0);
    line_q.push_back(ByteNewline);
    send_built_line();
    line_q.delete();
    open_kinds.delete();
    repeat (StackDepthDefault + 1) add_opener();
    line_q.push_back(ByteRoundOpen);
    line_q.push_back(ByteNewline);
    send_built_line();

    // Hold the output off while a burst of empty lines arrives, so that
    // both result slots fill and the input side has to stall.
    hold_request = 1'b1;
    repeat (12) send_byte(ByteNewline);

    // Random lines, with a stretch of lines that runs without any idling.
    sent    = 0;
    line_no = 0;
    while (sent < RandomItems) begin
      idle_en = !(line_no >= 20 && line_no < 35);
      build_line();
      send_built_line();
      sent += line_q.size();
      line_no++;
    end
    idle_en = 1'b1;
    s_axis_tvalid_i <= 1'b0;

    while (line_checker.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    line_checker.failures += line_checker.pending();
    if (line_checker.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### bracket_balance_checker_unit.f
sv/bbc_pkg.sv
sv/bbc_cell.sv
sv/bbc_stack.sv
sv/bracket_balance_checker_unit.sv
bench/bracket_balance_checker_unit_tb.sv
